[src/relativistic_boris_push_assert.svh]
// assertion macros shared by the pusher rtl
`ifndef RELATIVISTIC_BORIS_PUSH_ASSERT_SVH
`define RELATIVISTIC_BORIS_PUSH_ASSERT_SVH

// same-cycle implication
`define RBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/rbp_pkg.sv]
package rbp_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [63:0] Q_ONE  = 64'd65536;
   localparam logic [63:0] Q_TWO  = 64'd131072;
   localparam logic [63:0] Q_HALF = 64'd32768;

   // register index, taken from paddr[2]
   localparam logic REG_TIME_STEP   = 1'b0;
   localparam logic REG_CHARGE_MASS = 1'b1;

   // magnitude plus sign into a saturated w-bit word (low w bits of result)
   function automatic logic [63:0] sat_mag(input logic [127:0] m, input logic neg,
                                           input logic ovf, input int unsigned w);
      logic [127:0] lim;
      logic [127:0] r;
      lim = 128'd1 << (w - 1);
      if (neg) begin
         if (ovf || (m > lim)) r = 128'd0 - lim;
         else r = 128'd0 - m;
      end else begin
         if (ovf || (m >= lim)) r = lim - 128'd1;
         else r = m;
      end
      return r[63:0];
   endfunction

endpackage

[src/rbp_delay.sv]
module rbp_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];
endmodule

[src/rbp_qmul.sv]
module rbp_qmul #(
   parameter int WORD_BITS = rbp_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   output logic [WORD_BITS-1:0] p
);
   import rbp_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int HB = W / 2;
   localparam int HI = W - HB;

   logic [W-1:0]      ma_ff, mb_ff;
   logic              neg1_ff, neg2_ff;
   logic [W+HB-1:0]   plo_ff;
   logic [W+HI-1:0]   phi_ff;
   logic [2*W-1:0]    sum, rnd;
   logic [63:0]       sat;
   logic [W-1:0]      p_ff;

   // product split in two partial products, summed and rounded a stage later
   always_comb begin
      sum = {{HI{1'b0}}, plo_ff} + {phi_ff, {HB{1'b0}}};
      rnd = sum + (2*W)'(Q_HALF);
      sat = sat_mag(128'(rnd[2*W-1:FRAC_BITS]), neg2_ff, 1'b0, W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= a[W-1] ? (~a + W'(1)) : a;
         mb_ff   <= b[W-1] ? (~b + W'(1)) : b;
         neg1_ff <= a[W-1] ^ b[W-1];
         plo_ff  <= (W+HB)'(ma_ff) * (W+HB)'(mb_ff[HB-1:0]);
         phi_ff  <= (W+HI)'(ma_ff) * (W+HI)'(mb_ff[W-1:HB]);
         neg2_ff <= neg1_ff;
         p_ff    <= sat[W-1:0];
      end
   end

   assign p = p_ff;
endmodule

[src/rbp_qdiv.sv]
module rbp_qdiv #(
   parameter int WORD_BITS = rbp_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   output logic [WORD_BITS-1:0] q
);
   import rbp_pkg::*;

   localparam int W = WORD_BITS;

   logic [W-1:0] na_ff, da_ff;
   logic         nega_ff;

   logic [W-1:0] rem_ff [W+1];
   logic [W-1:0] quo_ff [W+1];
   logic [W-1:0] nb_ff  [W+1];
   logic [W-1:0] d_ff   [W+1];
   logic         neg_ff [W+1];
   logic         ovf_ff [W+1];

   logic         ovf_in, dz;
   logic         rnd;
   logic [W:0]   m;
   logic [63:0]  sat;
   logic [W-1:0] q_ff;

   // quotient past the word limit, or zero divisor with nonzero dividend
   always_comb begin
      dz     = (da_ff == '0);
      ovf_in = dz ? (na_ff != '0)
                  : ((2*W)'({na_ff, {FRAC_BITS{1'b0}}}) >= {da_ff, {W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff     <= a[W-1] ? (~a + W'(1)) : a;
         da_ff     <= b[W-1] ? (~b + W'(1)) : b;
         nega_ff   <= a[W-1] ^ b[W-1];
         rem_ff[0] <= dz ? '0 : W'(na_ff[W-1:W-FRAC_BITS]);
         nb_ff[0]  <= dz ? '0 : {na_ff[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
         d_ff[0]   <= dz ? W'(1) : da_ff;
         quo_ff[0] <= '0;
         neg_ff[0] <= nega_ff;
         ovf_ff[0] <= ovf_in;
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= W; k++) begin : g_digit
      logic [W:0] rs, diff;
      logic       ge;
      always_comb begin
         rs   = {rem_ff[k-1], nb_ff[k-1][W-1]};
         diff = rs - {1'b0, d_ff[k-1]};
         ge   = (rs >= {1'b0, d_ff[k-1]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[W-1:0] : rs[W-1:0];
            quo_ff[k] <= {quo_ff[k-1][W-2:0], ge};
            nb_ff[k]  <= {nb_ff[k-1][W-2:0], 1'b0};
            d_ff[k]   <= d_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // round to nearest, ties away from zero
   always_comb begin
      rnd = ({rem_ff[W], 1'b0} >= {1'b0, d_ff[W]});
      m   = {1'b0, quo_ff[W]} + (W+1)'(rnd);
      sat = sat_mag(128'(m), neg_ff[W], ovf_ff[W], W);
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= sat[W-1:0];
   end

   assign q = q_ff;
endmodule

[src/rbp_qsqrt.sv]
module rbp_qsqrt #(
   parameter int WORD_BITS = rbp_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [WORD_BITS-1:0] a,
   output logic [WORD_BITS-1:0] r
);
   import rbp_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int SB = (W + FRAC_BITS + 2) / 2;
   localparam int XW = 2 * SB;
   localparam int RB = SB + 2;

   logic [XW-1:0] x_ff    [SB+1];
   logic [RB-1:0] rem_ff  [SB+1];
   logic [SB-1:0] root_ff [SB+1];
   logic [SB:0]   f1;
   logic [W-1:0]  r_ff;

   // operand scaled by 2^18, non-positive gives zero
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= (a[W-1] || (a == '0)) ? '0
                       : (XW'(a[W-2:0]) << (FRAC_BITS + 2));
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   // one root bit per stage
   for (genvar k = 1; k <= SB; k++) begin : g_digit
      logic [RB-1:0] rs, trial;
      logic          ge;
      always_comb begin
         rs    = {rem_ff[k-1][RB-3:0], x_ff[k-1][XW-1:XW-2]};
         trial = {root_ff[k-1], 2'b01};
         ge    = (rs >= trial);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (rs - trial) : rs;
            root_ff[k] <= {root_ff[k-1][SB-2:0], ge};
            x_ff[k]    <= {x_ff[k-1][XW-3:0], 2'b00};
         end
      end
   end

   assign f1 = {1'b0, root_ff[SB]} + (SB+1)'(1);

   always_ff @(posedge clock) begin
      if (en) r_ff <= W'(f1[SB:1]);
   end

   assign r = r_ff;
endmodule

[src/relativistic_boris_push.sv]
// channel  | direction | handshake                  | payload
// req_     | in        | req_tvalid / req_tready    | req_tdata, 384 bits
// rsp_     | out       | rsp_tvalid / rsp_tready    | rsp_tdata, 224 bits
// csr_     | in        | psel, penable, pready = 1  | paddr 3 bits, pwdata/prdata 32
//
// one particle per cycle while the output is not held; the two bit-serial
// square roots, SB = (WORD_BITS + 18) / 2 bits wide, and the three one-bit-a-stage
// divider rows set the depth
// synchronous reset clears the valid bits and loads the register reset values
// a held output stalls the whole pipeline in place; req_tready follows it
`include "relativistic_boris_push_assert.svh"
module relativistic_boris_push #(
   parameter int WORD_BITS = rbp_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each)
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z (32 each),
   // lorentz_factor (31), one zero bit
   output logic [223:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rbp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import rbp_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int SB  = (W + FRAC_BITS + 2) / 2;
   localparam int LS  = SB + 2;
   localparam int LD  = W + 3;
   localparam int T_T = 15 + LS + LD;
   localparam int T_D = T_T + 5;
   localparam int T_S = T_D + LD;
   localparam int T_G = T_S + 10 + LS;
   localparam int LAT = T_G + LD;

   localparam logic [64:0]        LIM    = 65'd1 << (W - 1);
   localparam logic signed [64:0] WMAX_S = $signed(LIM - 65'd1);
   localparam logic signed [64:0] WMIN_S = -$signed(LIM);
   localparam logic [W-1:0]       ONE_W  = Q_ONE[W-1:0];
   localparam logic [W-1:0]       TWO_W  = Q_TWO[W-1:0];
   localparam logic [W-1:0]       HALF_W = Q_HALF[W-1:0];

   function automatic logic [W-1:0] sat_sum(input logic [W:0] s);
      if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] qadd(input logic [W-1:0] a, input logic [W-1:0] b);
      return sat_sum({a[W-1], a} + {b[W-1], b});
   endfunction

   function automatic logic [W-1:0] qsub(input logic [W-1:0] a, input logic [W-1:0] b);
      return sat_sum({a[W-1], a} - {b[W-1], b});
   endfunction

   function automatic logic [W-1:0] clamp_w(input logic signed [64:0] v);
      logic signed [64:0] c;
      c = (v > WMAX_S) ? WMAX_S : ((v < WMIN_S) ? WMIN_S : v);
      return c[W-1:0];
   endfunction

   function automatic logic [31:0] out32(input logic [W-1:0] v);
      logic signed [64:0] s, c;
      s = 65'($signed(v));
      c = (s > 65'sd2147483647) ? 65'sd2147483647
        : ((s < -65'sd2147483648) ? -65'sd2147483648 : s);
      return c[31:0];
   endfunction

   function automatic logic [30:0] gclamp(input logic [W-1:0] v);
      logic signed [64:0] s, c;
      s = 65'($signed(v));
      c = (s < 65'sd65536) ? 65'sd65536 : ((s > 65'sd2147483647) ? 65'sd2147483647 : s);
      return c[30:0];
   endfunction

   // configuration
   logic [30:0] time_step_ff;
   logic [31:0] cmr_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_CHARGE_MASS) ? cmr_ff : {1'b0, time_step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 31'd4118;
         cmr_ff       <= 32'd65536;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TIME_STEP:   time_step_ff <= csr_pwdata[30:0];
            REG_CHARGE_MASS: cmr_ff       <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // pipeline advance, held while a finished result waits
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   logic           valid0_ff;
   logic [LAT-1:0] vpipe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff    <= 1'b0;
         vpipe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid0_ff    <= req_tvalid;
         vpipe_ff     <= {vpipe_ff[LAT-2:0], valid0_ff};
         rsp_valid_ff <= vpipe_ff[LAT-1];
      end
   end

   // input stage
   logic [2:0][W-1:0] e0_ff, b0_ff, x0_ff, u0_ff;
   logic [W-1:0]      cmr0_ff, dt0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < 3; d++) begin
            e0_ff[d] <= clamp_w(65'($signed(req_tdata[32*d +: 32])));
            b0_ff[d] <= clamp_w(65'($signed(req_tdata[32*(3+d) +: 32])));
            x0_ff[d] <= clamp_w(65'($signed(req_tdata[32*(6+d) +: 32])));
            u0_ff[d] <= clamp_w(65'($signed(req_tdata[32*(9+d) +: 32])));
         end
         cmr0_ff <= clamp_w(65'($signed(cmr_ff)));
         dt0_ff  <= clamp_w($signed(65'(time_step_ff)));
      end
   end

   // kick factor k = (q/m * dt) / 2
   logic [W-1:0] h, kh;
   rbp_qmul #(.WORD_BITS(W)) u_mul_h  (.clock, .en, .a(cmr0_ff), .b(dt0_ff), .p(h));
   rbp_qmul #(.WORD_BITS(W)) u_mul_kh (.clock, .en, .a(HALF_W), .b(h), .p(kh));

   logic [2:0][W-1:0] e6, b6, u9, ek, kb, sq;
   logic [2:0][W-1:0] um_ff, kb_d, um_t, um_t4, um_s4, ek_s4;
   logic [2:0][W-1:0] tv, tt, tw, tw_d, sv, pa, pb, cr1_ff, up_ff, up_s;
   logic [2:0][W-1:0] qa, qb, cr2_ff, un_ff, usq, pd, pd_g, qx, x_l, un_l;
   logic [W-1:0]      dot1_ff, gsq_ff, gn, tdot_ff, den_ff, udot_ff, gsq2_ff, g, g_l, dt_s5;

   rbp_delay #(.WIDTH(3*W), .DEPTH(6))  u_dly_e  (.clock, .en, .din(e0_ff), .dout(e6));
   rbp_delay #(.WIDTH(3*W), .DEPTH(6))  u_dly_b  (.clock, .en, .din(b0_ff), .dout(b6));
   rbp_delay #(.WIDTH(3*W), .DEPTH(9))  u_dly_u  (.clock, .en, .din(u0_ff), .dout(u9));
   rbp_delay #(.WIDTH(W), .DEPTH(T_S+5)) u_dly_dt (.clock, .en, .din(dt0_ff), .dout(dt_s5));
   rbp_delay #(.WIDTH(3*W), .DEPTH(LAT)) u_dly_x (.clock, .en, .din(x0_ff), .dout(x_l));

   for (genvar d = 0; d < 3; d++) begin : g_kick
      rbp_qmul #(.WORD_BITS(W)) u_ek (.clock, .en, .a(e6[d]), .b(kh), .p(ek[d]));
      rbp_qmul #(.WORD_BITS(W)) u_kb (.clock, .en, .a(kh), .b(b6[d]), .p(kb[d]));
      rbp_qmul #(.WORD_BITS(W)) u_sq (.clock, .en, .a(um_ff[d]), .b(um_ff[d]), .p(sq[d]));
   end

   // half electric kick and gamma of u-
   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < 3; d++) um_ff[d] <= qadd(u9[d], ek[d]);
         dot1_ff <= qadd(qadd(sq[0], sq[1]), sq[2]);
         gsq_ff  <= qadd(ONE_W, dot1_ff);
      end
   end

   rbp_qsqrt #(.WORD_BITS(W)) u_sqrt_gn (.clock, .en, .a(gsq_ff), .r(gn));
   rbp_delay #(.WIDTH(3*W), .DEPTH(6+LS)) u_dly_kb (.clock, .en, .din(kb), .dout(kb_d));
   rbp_delay #(.WIDTH(3*W), .DEPTH(T_T-10)) u_dly_um (.clock, .en, .din(um_ff), .dout(um_t));
   rbp_delay #(.WIDTH(3*W), .DEPTH(4)) u_dly_um4 (.clock, .en, .din(um_t), .dout(um_t4));
   rbp_delay #(.WIDTH(3*W), .DEPTH(5+LD)) u_dly_ums (.clock, .en, .din(um_t4), .dout(um_s4));
   rbp_delay #(.WIDTH(3*W), .DEPTH(T_S-5)) u_dly_ek (.clock, .en, .din(ek), .dout(ek_s4));

   // rotation vectors t and s, both cross products, new-u squares and position step dt*u/gamma
   for (genvar d = 0; d < 3; d++) begin : g_rot
      rbp_qdiv #(.WORD_BITS(W)) u_tv (.clock, .en, .a(kb_d[d]), .b(gn), .q(tv[d]));
      rbp_qmul #(.WORD_BITS(W)) u_tt (.clock, .en, .a(tv[d]), .b(tv[d]), .p(tt[d]));
      rbp_qmul #(.WORD_BITS(W)) u_tw (.clock, .en, .a(TWO_W), .b(tv[d]), .p(tw[d]));
      rbp_qdiv #(.WORD_BITS(W)) u_sv (.clock, .en, .a(tw_d[d]), .b(den_ff), .q(sv[d]));
      rbp_qmul #(.WORD_BITS(W)) u_pa (.clock, .en, .a(um_t[(d+1)%3]), .b(tv[(d+2)%3]),
                                      .p(pa[d]));
      rbp_qmul #(.WORD_BITS(W)) u_pb (.clock, .en, .a(tv[(d+1)%3]), .b(um_t[(d+2)%3]),
                                      .p(pb[d]));
      rbp_qmul #(.WORD_BITS(W)) u_qa (.clock, .en, .a(up_s[(d+1)%3]), .b(sv[(d+2)%3]),
                                      .p(qa[d]));
      rbp_qmul #(.WORD_BITS(W)) u_qb (.clock, .en, .a(sv[(d+1)%3]), .b(up_s[(d+2)%3]),
                                      .p(qb[d]));
      rbp_qmul #(.WORD_BITS(W)) u_usq (.clock, .en, .a(un_ff[d]), .b(un_ff[d]),
                                       .p(usq[d]));
      rbp_qmul #(.WORD_BITS(W)) u_pd (.clock, .en, .a(dt_s5), .b(un_ff[d]), .p(pd[d]));
      rbp_qdiv #(.WORD_BITS(W)) u_qx (.clock, .en, .a(pd_g[d]), .b(g), .q(qx[d]));
   end

   rbp_delay #(.WIDTH(3*W), .DEPTH(2))  u_dly_tw (.clock, .en, .din(tw), .dout(tw_d));
   rbp_delay #(.WIDTH(3*W), .DEPTH(LD)) u_dly_up (.clock, .en, .din(up_ff), .dout(up_s));

   always_ff @(posedge clock) begin
      if (en) begin
         tdot_ff <= qadd(qadd(tt[0], tt[1]), tt[2]);
         den_ff  <= qadd(ONE_W, tdot_ff);
         for (int d = 0; d < 3; d++) begin
            cr1_ff[d] <= qsub(pa[d], pb[d]);
            up_ff[d]  <= qadd(um_t4[d], cr1_ff[d]);
            cr2_ff[d] <= qsub(qa[d], qb[d]);
            // second rotation and the other half kick
            un_ff[d]  <= qadd(qadd(um_s4[d], cr2_ff[d]), ek_s4[d]);
         end
         udot_ff <= qadd(qadd(usq[0], usq[1]), usq[2]);
         gsq2_ff <= qadd(ONE_W, udot_ff);
      end
   end

   // new gamma and position update
   rbp_qsqrt #(.WORD_BITS(W)) u_sqrt_g (.clock, .en, .a(gsq2_ff), .r(g));
   rbp_delay #(.WIDTH(3*W), .DEPTH(2+LS)) u_dly_pd (.clock, .en, .din(pd), .dout(pd_g));
   rbp_delay #(.WIDTH(3*W), .DEPTH(5+LS+LD)) u_dly_un (.clock, .en, .din(un_ff), .dout(un_l));
   rbp_delay #(.WIDTH(W), .DEPTH(LD)) u_dly_g (.clock, .en, .din(g), .dout(g_l));

   logic [2:0][31:0] pos_out_ff, vel_out_ff;
   logic [30:0]      gam_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < 3; d++) begin
            pos_out_ff[d] <= out32(qadd(x_l[d], qx[d]));
            vel_out_ff[d] <= out32(un_l[d]);
         end
         gam_out_ff <= gclamp(g_l);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, gam_out_ff, vel_out_ff, pos_out_ff};

   `RBP_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !en && !reset, $stable(vpipe_ff))
   `RBP_ASSERT_NEXT(a_transfer_enters, clock, reset, req_tvalid && req_tready, valid0_ff)
   `RBP_ASSERT_IMPL(a_gamma_floor, clock, reset, rsp_tvalid, rsp_tdata[222:192] >= 31'd65536)
   `RBP_ASSERT_NEXT(a_time_step_write, clock, reset,
      csr_wr && (csr_paddr[2] == REG_TIME_STEP), time_step_ff == $past(csr_pwdata[30:0]))
endmodule
